FILE: rtl/core/sorted_table_insert_find_unit_macros.svh
// Assertion macros shared by the sorted table RTL
`ifndef SORTED_TABLE_INSERT_FIND_UNIT_MACROS_SVH
`define SORTED_TABLE_INSERT_FIND_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define STIF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define STIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/stif_pkg.sv
// Package: types, codes and defaults of the sorted table unit
`default_nettype none
package stif_pkg;

  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_ENTRY_WIDTH = 32;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_MISS     = 2'd2,
    STATUS_UNSORTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT,
    ST_PLACE,
    ST_MATCH,
    ST_READ,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/stif_channels.sv
// Interfaces: command and response channels of the sorted table unit
`default_nettype none
interface stif_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [stif_pkg::MODE_W-1:0]   mode;
  logic [stif_pkg::VALUE_W-1:0]  entry_value;
  logic [stif_pkg::INDEX_W-1:0]  index;

  modport source (output valid, mode, entry_value, index, input ready);
  modport sink   (input valid, mode, entry_value, index, output ready);
endinterface

interface stif_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [stif_pkg::STATUS_W-1:0] status;
  logic [stif_pkg::POS_W-1:0]    position;
  logic [stif_pkg::VALUE_W-1:0]  entry_out;
  logic [stif_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, position, entry_out, entry_count, input ready);
  modport sink   (input valid, status, position, entry_out, entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sorted_table_insert_find_unit.sv
// Top level: sorted table with insert, find and read over one entry memory
//
// One transaction at a time runs against a single memory with one read and
// one write port and registered read data. Each binary search step is a
// read followed by a compare. A sorted insert searches, then moves every
// entry above the insert point up by one and places the new entry; an
// unsorted insert places it at the end without a search. A find searches
// and then reads the entry below the insert point for a match, or misses
// at once when no entry lies at or below the key. Every moved entry is one
// read and one write. The fill count bounds every read, so the memory needs
// no clearing after reset. The next command is taken while the last response
// still waits in the output register.
`default_nettype none
`include "sorted_table_insert_find_unit_macros.svh"
module sorted_table_insert_find_unit #(
  parameter int CAPACITY    = stif_pkg::DEF_CAPACITY,
  parameter int ENTRY_WIDTH = stif_pkg::DEF_ENTRY_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  stif_cmd_if.sink   cmd,
  stif_rsp_if.source rsp,
  input  wire logic cfg_wen,
  input  wire logic cfg_wdata
);

  import stif_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t                 state, state_next;
  logic                   keep_sorted;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          lo, lo_next;
  logic [CW-1:0]          hi, hi_next;
  logic [CW-1:0]          ptr, ptr_next;
  logic [AW-1:0]          mid, mid_next;
  logic                   wpend, wpend_next;
  logic [AW-1:0]          waddr, waddr_next;
  mode_t                  mode_q, mode_next;
  logic [ENTRY_WIDTH-1:0] val_q, val_next;
  status_t                res_status, res_status_next;
  logic [AW-1:0]          res_pos, res_pos_next;
  logic [ENTRY_WIDTH-1:0] res_data, res_data_next;
  logic                   out_valid, out_valid_next;
  status_t                out_status, out_status_next;
  logic [AW-1:0]          out_pos, out_pos_next;
  logic [ENTRY_WIDTH-1:0] out_data, out_data_next;
  logic [CW-1:0]          out_count, out_count_next;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [ENTRY_WIDTH-1:0] rd_data, wr_data;

  logic [CW-1:0]             mid_w, lo_m1, ptr_m1;
  logic [ENTRY_WIDTH+31:0]   val_ext;
  logic [CW+7:0]             idx_wide, count_wide;
  logic                      idx_ok;
  logic [AW+7:0]             pos_ext;
  logic [ENTRY_WIDTH+31:0]   data_ext;
  logic [CW+8:0]             count_ext;

  stif_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign val_ext    = {{ENTRY_WIDTH{1'b0}}, cmd.entry_value};
  assign idx_wide   = {{CW{1'b0}}, cmd.index};
  assign count_wide = {8'b0, count};
  assign idx_ok     = idx_wide < count_wide;
  assign mid_w      = lo + ((hi - lo) >> 1);
  assign lo_m1      = lo - CW'(1);
  assign ptr_m1     = ptr - CW'(1);

  assign cmd.ready = (state == ST_IDLE);

  assign pos_ext   = {8'b0, out_pos};
  assign data_ext  = {32'b0, out_data};
  assign count_ext = {9'b0, out_count};

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = pos_ext[POS_W-1:0];
  assign rsp.entry_out   = data_ext[VALUE_W-1:0];
  assign rsp.entry_count = count_ext[COUNT_W-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    ptr_next        = ptr;
    mid_next        = mid;
    wpend_next      = wpend;
    waddr_next      = waddr;
    mode_next       = mode_q;
    val_next        = val_q;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_data_next   = res_data;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_pos_next    = out_pos;
    out_data_next   = out_data;
    out_count_next  = out_count;
    rd_en           = 1'b0;
    rd_addr         = mid_w[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = waddr;
    wr_data         = rd_data;

    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          mode_next     = mode_t'(cmd.mode);
          val_next      = val_ext[ENTRY_WIDTH-1:0];
          res_pos_next  = '0;
          res_data_next = '0;
          lo_next       = '0;
          hi_next       = count;
          unique case (mode_t'(cmd.mode))
            MODE_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                res_status_next = STATUS_FULL;
                state_next      = ST_DONE;
              end else if (!keep_sorted) begin
                lo_next    = count;
                state_next = ST_PLACE;
              end else begin
                state_next = ST_SEARCH;
              end
            end
            MODE_FIND: begin
              if (!keep_sorted) begin
                res_status_next = STATUS_UNSORTED;
                state_next      = ST_DONE;
              end else begin
                state_next = ST_SEARCH;
              end
            end
            MODE_READ: begin
              if (idx_ok) begin
                rd_en      = 1'b1;
                rd_addr    = idx_wide[AW-1:0];
                state_next = ST_READ;
              end else begin
                res_status_next = STATUS_MISS;
                state_next      = ST_DONE;
              end
            end
            default: begin
              res_status_next = STATUS_MISS;
              state_next      = ST_DONE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          rd_addr    = mid_w[AW-1:0];
          mid_next   = mid_w[AW-1:0];
          state_next = ST_COMPARE;
        end else if (mode_q == MODE_INSERT) begin
          ptr_next   = count;
          wpend_next = 1'b0;
          state_next = ST_SHIFT;
        end else if (lo == '0) begin
          res_status_next = STATUS_MISS;
          state_next      = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lo_m1[AW-1:0];
          mid_next   = lo_m1[AW-1:0];
          state_next = ST_MATCH;
        end
      end
      ST_COMPARE: begin
        if (rd_data > val_q) begin
          hi_next = CW'(mid);
        end else begin
          lo_next = CW'(mid) + CW'(1);
        end
        state_next = ST_SEARCH;
      end
      ST_SHIFT: begin
        wr_en   = wpend;
        wr_addr = waddr;
        wr_data = rd_data;
        if (ptr > lo) begin
          rd_en      = 1'b1;
          rd_addr    = ptr_m1[AW-1:0];
          waddr_next = ptr[AW-1:0];
          wpend_next = 1'b1;
          ptr_next   = ptr_m1;
        end else begin
          wpend_next = 1'b0;
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        wr_en           = 1'b1;
        wr_addr         = lo[AW-1:0];
        wr_data         = val_q;
        count_next      = count + CW'(1);
        res_status_next = STATUS_OK;
        res_pos_next    = lo[AW-1:0];
        state_next      = ST_DONE;
      end
      ST_MATCH: begin
        if (rd_data == val_q) begin
          res_status_next = STATUS_OK;
          res_pos_next    = mid;
        end else begin
          res_status_next = STATUS_MISS;
        end
        state_next = ST_DONE;
      end
      ST_READ: begin
        res_status_next = STATUS_OK;
        res_data_next   = rd_data;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_pos_next    = res_pos;
          out_data_next   = res_data;
          out_count_next  = count;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      wpend       <= 1'b0;
      out_valid   <= 1'b0;
      keep_sorted <= 1'b1;
    end else begin
      state     <= state_next;
      count     <= count_next;
      wpend     <= wpend_next;
      out_valid <= out_valid_next;
      if (cfg_wen) begin
        keep_sorted <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    ptr        <= ptr_next;
    mid        <= mid_next;
    waddr      <= waddr_next;
    mode_q     <= mode_next;
    val_q      <= val_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_data   <= res_data_next;
    out_status <= out_status_next;
    out_pos    <= out_pos_next;
    out_data   <= out_data_next;
    out_count  <= out_count_next;
  end

  `STIF_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY), "fill count above capacity")
  `STIF_ASSERT_IMP(a_count_step, count != $past(count), count == $past(count) + CW'(1), "bad step")
  `STIF_ASSERT_IMP(a_write_bound, wr_en, CW'(wr_addr) <= count, "write beyond fill count")
  `STIF_ASSERT_IMP(a_search_window, state == ST_COMPARE, lo < hi, "empty search window")
  `STIF_ASSERT_NEXT(a_place_done, state == ST_PLACE, state == ST_DONE, "place without done")
  `STIF_ASSERT_NEXT(a_place_ok, state == ST_PLACE, res_status == STATUS_OK, "place without ok")

endmodule
`default_nettype wire

FILE: rtl/core/stif_store.sv
// Entry store: single-port-read, single-port-write memory with registered read data
`default_nettype none
module stif_store #(
  parameter int DEPTH = stif_pkg::DEF_CAPACITY,
  parameter int WIDTH = stif_pkg::DEF_ENTRY_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
